[rtl/rqss_pkg.sv]
package rqss_pkg;

	localparam int PROCESS_SLOTS = 256;
	localparam int ID_W = 8;
	localparam int BURST_W = 16;
	localparam int PRIO_W = 8;
	localparam int TIME_W = 16;
	localparam int KEY_W = 16;
	localparam int MODE_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [TIME_W-1:0] TIME_SLICE_RESET = TIME_W'(4);

	typedef enum logic [MODE_W-1:0] {
		POL_FCFS    = 3'd0,
		POL_SJF_NP  = 3'd1,
		POL_SJF_P   = 3'd2,
		POL_PRIO_NP = 3'd3,
		POL_PRIO_P  = 3'd4,
		POL_RR      = 3'd5
	} policy_t;

	typedef enum logic {
		CFG_POLICY_MODE = 1'b0,
		CFG_TIME_SLICE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               first;
		logic               last;
		logic               has_running;
		logic [ID_W-1:0]    running_id;
		logic [BURST_W-1:0] running_burst;
		logic [PRIO_W-1:0]  running_prio;
		logic [TIME_W-1:0]  elapsed_time;
		logic               entry_valid;
		logic [ID_W-1:0]    entry_id;
		logic [BURST_W-1:0] entry_burst;
		logic [PRIO_W-1:0]  entry_prio;
	} item_t;

	typedef struct packed {
		logic            chosen_valid;
		logic [ID_W-1:0] chosen_id;
		logic            from_queue;
		logic            restart_slice;
	} result_t;

	typedef struct packed {
		logic             best_valid;
		logic             best_from_queue;
		logic             slice_restart;
		logic [ID_W-1:0]  best_id;
		logic [KEY_W-1:0] best_key;
	} sel_state_t;

	function automatic logic id_in_table(input logic [ID_W-1:0] id);
		return 32'(id) < PROCESS_SLOTS;
	endfunction

endpackage

[rtl/rqss_select.sv]
module rqss_select (
	input  logic [rqss_pkg::MODE_W-1:0] mode,
	input  logic [rqss_pkg::TIME_W-1:0] time_slice,
	input  rqss_pkg::sel_state_t        cur,
	input  rqss_pkg::item_t             item,
	output rqss_pkg::sel_state_t        nxt,
	output rqss_pkg::result_t           result
);
	import rqss_pkg::*;

	logic       is_sjf;
	logic       is_prio;
	logic       preempt;
	logic       is_rr;
	logic       is_fcfs;
	logic       run;
	logic [KEY_W-1:0] entry_key;
	sel_state_t opened;

	assign is_sjf  = (mode == POL_SJF_NP) || (mode == POL_SJF_P);
	assign is_prio = (mode == POL_PRIO_NP) || (mode == POL_PRIO_P);
	assign preempt = (mode == POL_SJF_P) || (mode == POL_PRIO_P);
	assign is_rr   = (mode == POL_RR);
	assign is_fcfs = !(is_sjf || is_prio || is_rr);
	assign run     = item.has_running && id_in_table(item.running_id);
	assign entry_key = is_sjf ? item.entry_burst : KEY_W'(item.entry_prio);

	// decision setup on the first item
	always_comb begin
		opened = cur;
		if (item.first) begin
			opened = '0;
			if (is_fcfs) begin
				opened.best_key = KEY_W'(1);
			end else if (is_rr) begin
				if (!run) begin
					opened.best_key      = KEY_W'(1);
					opened.slice_restart = 1'b1;
				end else begin
					opened.best_valid = 1'b1;
					opened.best_id    = item.running_id;
					if (item.elapsed_time >= time_slice) begin
						opened.best_key      = KEY_W'(1);
						opened.slice_restart = 1'b1;
					end
				end
			end else if (preempt && run) begin
				opened.best_valid = 1'b1;
				opened.best_id    = item.running_id;
				opened.best_key   = is_sjf ? item.running_burst : KEY_W'(item.running_prio);
			end
		end
	end

	// queue entry against the running best
	always_comb begin
		nxt = opened;
		if (item.entry_valid && id_in_table(item.entry_id)) begin
			if (is_fcfs || is_rr) begin
				if (opened.best_key != '0) begin
					nxt.best_valid      = 1'b1;
					nxt.best_id         = item.entry_id;
					nxt.best_from_queue = 1'b1;
					nxt.best_key        = '0;
				end
			end else if (!opened.best_valid || (entry_key < opened.best_key)) begin
				nxt.best_valid      = 1'b1;
				nxt.best_id         = item.entry_id;
				nxt.best_key        = entry_key;
				nxt.best_from_queue = 1'b1;
			end
		end
	end

	always_comb begin
		result.chosen_valid  = nxt.best_valid;
		result.chosen_id     = nxt.best_valid ? nxt.best_id : '0;
		result.from_queue    = nxt.best_valid && nxt.best_from_queue;
		result.restart_slice = nxt.slice_restart;
	end

endmodule

[rtl/ready_queue_scheduler_select_core.sv]
// Ready-queue scheduler select.
// Input channel (item_valid/item_ready/item): the ready-queue entries of one
// scheduling decision, one item each, in queue order. The first item of a
// decision carries the running process and its elapsed slice time; an empty
// queue is sent as one item with entry_valid low. The item marked last
// closes the decision and makes exactly one result.
// Output channel (result_valid/result_ready/result): the chosen process, or
// none, with from_queue and restart_slice.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (policy mode, time slice) in the same cycle; write only while idle.
// Throughput: one item per cycle while item_ready is high. Each item is
// compared with the running best in one pass of logic that feeds the
// state and result registers. The result is valid in the cycle after the
// last item is accepted. A stalled result is held in the output register;
// the next items are still taken as long as the result register is free
// or is being emptied in the same cycle.
// Reset: policy mode fcfs, time slice 4, selection state cleared, no
// result pending.
module ready_queue_scheduler_select_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  rqss_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output rqss_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [rqss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rqss_pkg::*;

	logic [MODE_W-1:0] policy_q;
	logic [TIME_W-1:0] slice_q;
	sel_state_t        state_q;
	sel_state_t        state_nxt;
	result_t           result_nxt;
	result_t           result_q;
	logic              result_valid_q;
	logic              accept;

	rqss_select u_select (
		.mode       (policy_q),
		.time_slice (slice_q),
		.cur        (state_q),
		.item       (item),
		.nxt        (state_nxt),
		.result     (result_nxt)
	);

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
			slice_q  <= TIME_SLICE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY_MODE: policy_q <= cfg_data[MODE_W-1:0];
				CFG_TIME_SLICE:  slice_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_ready) begin
			result_valid_q <= accept && item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.last) begin
			result_q <= result_nxt;
		end
	end

endmodule

[rtl/rqss_checker.sv]
module rqss_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input rqss_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input rqss_pkg::result_t result
);
	import rqss_pkg::*;

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a last item gives a result in the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last |=> result_valid)
		else $error("last item gave no result");

	// no result without a last item or a pending stall
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(arst_n) |->
			$past(item_valid && item_ready && item.last) ||
			$past(result_valid && !result_ready))
		else $error("result without a last item");

	// none chosen means empty id and not from queue
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chosen_valid |->
			result.chosen_id == '0 && !result.from_queue)
		else $error("none result carries data");

	// free output register never blocks the input
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input blocked with empty output");

endmodule

bind ready_queue_scheduler_select_core rqss_checker u_rqss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

[verif/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rqss_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 2000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam logic [MODE_W-1:0] POL_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] POL_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item_bus = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result_bus;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [MODE_W-1:0] cur_mode = POL_FCFS;
	logic [TIME_W-1:0] cur_slice = TIME_SLICE_RESET;
	sel_state_t sel = '0;
	result_t pending_choices[$];
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap_pct = 29;
	int unsigned recv_stall_pct = 69;

	ready_queue_scheduler_select_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item_bus),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// selection state update for one item; returns 1 when the item closes a decision
	function automatic bit predict_choice(input item_t it, output result_t r);
		logic sjf, prio, preempt, rr, fcfs, run;
		logic [KEY_W-1:0] key;
		sjf = cur_mode == POL_SJF_NP || cur_mode == POL_SJF_P;
		prio = cur_mode == POL_PRIO_NP || cur_mode == POL_PRIO_P;
		preempt = cur_mode == POL_SJF_P || cur_mode == POL_PRIO_P;
		rr = cur_mode == POL_RR;
		fcfs = !(sjf || prio || rr);
		if (it.first) begin
			run = it.has_running && 32'(it.running_id) < PROCESS_SLOTS;
			sel = '0;
			if (fcfs) begin
				sel.best_key = KEY_W'(1);
			end else if (rr) begin
				if (!run) begin
					sel.best_key = KEY_W'(1);
					sel.slice_restart = 1'b1;
				end else begin
					sel.best_valid = 1'b1;
					sel.best_id = it.running_id;
					if (it.elapsed_time >= cur_slice) begin
						sel.best_key = KEY_W'(1);
						sel.slice_restart = 1'b1;
					end
				end
			end else if (preempt && run) begin
				sel.best_valid = 1'b1;
				sel.best_id = it.running_id;
				sel.best_key = sjf ? it.running_burst : KEY_W'(it.running_prio);
			end
		end
		if (it.entry_valid && 32'(it.entry_id) < PROCESS_SLOTS) begin
			if (fcfs || rr) begin
				if (sel.best_key != '0) begin
					sel.best_valid = 1'b1;
					sel.best_id = it.entry_id;
					sel.best_from_queue = 1'b1;
					sel.best_key = '0;
				end
			end else begin
				key = sjf ? it.entry_burst : KEY_W'(it.entry_prio);
				if (!sel.best_valid || key < sel.best_key) begin
					sel.best_valid = 1'b1;
					sel.best_id = it.entry_id;
					sel.best_key = key;
					sel.best_from_queue = 1'b1;
				end
			end
		end
		r.chosen_valid = sel.best_valid;
		r.chosen_id = sel.best_valid ? sel.best_id : '0;
		r.from_queue = sel.best_valid & sel.best_from_queue;
		r.restart_slice = sel.slice_restart;
		return it.last;
	endfunction

	function automatic item_t make_item(input bit first, input bit last, input bit has_run,
			input logic [ID_W-1:0] run_id, input logic [BURST_W-1:0] run_burst,
			input logic [PRIO_W-1:0] run_prio, input logic [TIME_W-1:0] elapsed,
			input bit ev, input logic [ID_W-1:0] eid, input logic [BURST_W-1:0] eburst,
			input logic [PRIO_W-1:0] eprio);
		item_t it;
		it.first = first;
		it.last = last;
		it.has_running = has_run;
		it.running_id = run_id;
		it.running_burst = run_burst;
		it.running_prio = run_prio;
		it.elapsed_time = elapsed;
		it.entry_valid = ev;
		it.entry_id = eid;
		it.entry_burst = eburst;
		it.entry_prio = eprio;
		return it;
	endfunction

	// small keys half the time so that ties are common
	function automatic logic [KEY_W-1:0] rand_key();
		return $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.first = 1'b0;
		it.last = 1'b0;
		it.has_running = $urandom_range(0, 3) != 0;
		it.running_id = ID_W'($urandom);
		it.running_burst = rand_key();
		it.running_prio = PRIO_W'(rand_key());
		case ($urandom_range(0, 3))
			0: it.elapsed_time = cur_slice;
			1: it.elapsed_time = cur_slice - 1'b1;
			2: it.elapsed_time = cur_slice + 1'b1;
			default: it.elapsed_time = TIME_W'($urandom);
		endcase
		it.entry_valid = 1'b1;
		it.entry_id = ID_W'($urandom);
		it.entry_burst = rand_key();
		it.entry_prio = PRIO_W'(rand_key());
		return it;
	endfunction

	task automatic report_failure(input string what, input result_t want, input result_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s: expected valid=%0d id=%0d from_queue=%0d restart=%0d, got valid=%0d id=%0d from_queue=%0d restart=%0d",
				what, want.chosen_valid, want.chosen_id, want.from_queue, want.restart_slice,
				got.chosen_valid, got.chosen_id, got.from_queue, got.restart_slice);
	endtask

	task automatic send_item(input item_t it);
		result_t r;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		item_valid <= 1'b1;
		item_bus <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		if (predict_choice(it, r))
			pending_choices.push_back(r);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_choices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] slice,
			input bit slice_too);
		logic [CFG_DATA_W-1:0] word;
		wait_idle();
		word = CFG_DATA_W'($urandom);
		word[MODE_W-1:0] = mode;
		cfg_we <= 1'b1;
		cfg_index <= CFG_POLICY_MODE;
		cfg_data <= word;
		@(posedge clk);
		cur_mode = mode;
		if (slice_too) begin
			cfg_index <= CFG_TIME_SLICE;
			cfg_data <= slice;
			@(posedge clk);
			cur_slice = slice;
		end
		cfg_we <= 1'b0;
	endtask

	// entries == 0 sends an empty queue as one item
	task automatic send_decision(input int unsigned entries, input bit with_first,
			input bit with_last);
		item_t it;
		int unsigned n;
		n = entries == 0 ? 1 : entries;
		for (int unsigned k = 0; k < n; k++) begin
			it = rand_item();
			it.first = with_first && k == 0;
			it.last = with_last && k == n - 1;
			it.entry_valid = entries != 0 && $urandom_range(0, 19) != 0;
			send_item(it);
		end
	endtask

	task automatic test_reset_values();
		// before any first item
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd9, 16'd1, 8'd1));
		send_item(make_item(1, 0, 1, 8'd5, 16'd1, 8'd1, 16'd9, 1, 8'd200, 16'd7, 8'd3));
		send_item(make_item(0, 0, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd17, 16'd0, 8'd0));
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd255, 16'd0, 8'd0));
		configure(POL_RR, '0, 1'b0);
		send_item(make_item(1, 1, 1, 8'd42, 16'd5, 8'd5, 16'd3, 1, 8'd7, 16'd1, 8'd1));
		send_item(make_item(1, 0, 1, 8'd42, 16'd5, 8'd5, 16'd4, 1, 8'd7, 16'd1, 8'd1));
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd8, 16'd1, 8'd1));
		send_item(make_item(1, 1, 1, 8'd42, 16'd5, 8'd5, 16'hFFFF, 0, 8'd0, 16'd0, 8'd0));
		send_item(make_item(1, 1, 0, 8'd42, 16'd5, 8'd5, 16'd0, 1, 8'd0, 16'd0, 8'd0));
	endtask

	task automatic test_special_cases();
		configure(POL_SJF_NP, 16'hFFFF, 1'b1);
		send_item(make_item(1, 0, 1, 8'd9, 16'd0, 8'd0, 16'd0, 1, 8'd1, 16'hFFFF, 8'd0));
		send_item(make_item(0, 0, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd2, 16'd3, 8'd0));
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd3, 16'd3, 8'd0));
		send_item(make_item(1, 1, 1, 8'd9, 16'd0, 8'd0, 16'd0, 0, 8'd0, 16'd0, 8'd0));
		configure(POL_SJF_P, '0, 1'b1);
		send_item(make_item(1, 1, 1, 8'd50, 16'd2, 8'd0, 16'd0, 1, 8'd51, 16'd2, 8'd0));
		send_item(make_item(1, 1, 1, 8'd50, 16'd9, 8'd0, 16'd0, 1, 8'd52, 16'd8, 8'd0));
		send_item(make_item(1, 1, 1, 8'd50, 16'd9, 8'd0, 16'd0, 0, 8'd0, 16'd0, 8'd0));
		configure(POL_PRIO_NP, '0, 1'b0);
		send_item(make_item(1, 0, 1, 8'd60, 16'd0, 8'd0, 16'd0, 1, 8'd3, 16'd0, 8'd255));
		send_item(make_item(0, 0, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd4, 16'd0, 8'd0));
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd5, 16'd0, 8'd0));
		configure(POL_PRIO_P, '0, 1'b0);
		send_item(make_item(1, 1, 1, 8'd60, 16'd0, 8'h80, 16'd0, 1, 8'd61, 16'd0, 8'h7F));
		send_item(make_item(1, 1, 0, 8'd60, 16'd0, 8'h80, 16'd0, 0, 8'd0, 16'd0, 8'd0));
		configure(POL_SPARE_LO, '0, 1'b0);
		send_item(make_item(1, 1, 1, 8'd1, 16'd0, 8'd0, 16'd0, 1, 8'd77, 16'd0, 8'd0));
		configure(POL_SPARE_HI, '0, 1'b0);
		send_item(make_item(1, 1, 1, 8'd1, 16'd0, 8'd0, 16'd0, 0, 8'd0, 16'd0, 8'd0));
		// no first: front entry still wanted from the empty decision
		send_item(make_item(0, 1, 0, 8'd0, 16'd0, 8'd0, 16'd0, 1, 8'd99, 16'd0, 8'd0));
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		item_t it;
		int unsigned start;
		int unsigned entries;
		logic [TIME_W-1:0] slice;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: slice = '0;
					1: slice = '1;
					2: slice = TIME_W'($urandom_range(1, 8));
					default: slice = TIME_W'($urandom);
				endcase
				configure(MODE_W'($urandom_range(0, 7)), slice, $urandom_range(0, 1) != 0);
			end
			entries = $urandom_range(0, 9) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 5);
			case ($urandom_range(0, 19))
				0, 1: begin
					it = rand_item();
					it.first = 1'($urandom);
					it.last = 1'($urandom);
					it.entry_valid = 1'($urandom);
					send_item(it);
				end
				2: send_decision(entries, 1'b0, 1'b1);
				3: send_decision(entries, 1'b1, 1'b0);
				default: send_decision(entries, 1'b1, 1'b1);
			endcase
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_choices.size() == 0) begin
				report_failure("unexpected result", '0, result_bus);
			end else begin
				want = pending_choices.pop_front();
				if (result_bus.chosen_valid !== want.chosen_valid
						|| result_bus.chosen_id !== want.chosen_id
						|| result_bus.from_queue !== want.from_queue
						|| result_bus.restart_slice !== want.restart_slice)
					report_failure("mismatch", want, result_bus);
			end
		end
		result_ready <= $urandom_range(0, 99) >= recv_stall_pct;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_special_cases();
		test_random_traffic(600);
		send_gap_pct = 69;
		recv_stall_pct = 29;
		test_random_traffic(600);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(550);
		item_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending_choices.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_choices.size() != 0) begin
			fail_count++;
			$display("%0d results never arrived", pending_choices.size());
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/rqss_pkg.sv
rtl/rqss_select.sv
rtl/ready_queue_scheduler_select_core.sv
rtl/rqss_checker.sv
verif/tb_top.sv
